// ----- hdl/asfe_pkg.sv -----
// ----------------------------------------------------------------------------
// asfe_pkg: shared definitions for the audio sample format expander
// Holds the sample format codes and the G.711 expansion constants.
// ----------------------------------------------------------------------------
package asfe_pkg;

  // Sample format codes held in the configuration register.
  typedef enum logic [2:0] {
    FMT_PCM8    = 3'd0,
    FMT_PCM16   = 3'd1,
    FMT_PCM24   = 3'd2,
    FMT_PCM32   = 3'd3,
    FMT_FLOAT32 = 3'd4,
    FMT_FLOAT64 = 3'd5,
    FMT_ALAW    = 3'd6,
    FMT_MULAW   = 3'd7
  } sample_fmt_t;

  localparam sample_fmt_t FMT_RESET = FMT_PCM16;

  // G.711 expansion constants.
  localparam logic [7:0]  ALAW_XOR       = 8'h55;
  localparam logic [15:0] ALAW_SEG0_BIAS = 16'h0008;
  localparam logic [15:0] ALAW_SEG_BIAS  = 16'h0108;
  localparam logic [15:0] MULAW_BIAS     = 16'h0084;

  // Request into the G.711 expander.
  typedef struct packed {
    logic [7:0] code;
    logic       is_mulaw;
  } g711_req_t;

endpackage

// ----- hdl/asfe_g711_exp.sv -----
// ----------------------------------------------------------------------------
// asfe_g711_exp: G.711 A-law / mu-law code to 16-bit linear
// Combinational expander; the result is a 16-bit two's complement value.
// ----------------------------------------------------------------------------
module asfe_g711_exp (
  input  asfe_pkg::g711_req_t req,
  output logic [15:0]         lin
);

  logic [7:0]  a_v;
  logic [2:0]  a_seg;
  logic [15:0] a_mant;
  logic [15:0] a_mag;
  logic [15:0] a_lin;
  logic [7:0]  u_v;
  logic [15:0] u_mag;
  logic [15:0] u_lin;

  always_comb begin
    a_v    = req.code ^ asfe_pkg::ALAW_XOR;
    a_seg  = a_v[6:4];
    a_mant = {8'h00, a_v[3:0], 4'h0};
    unique case (a_seg)
      3'd0:    a_mag = a_mant + asfe_pkg::ALAW_SEG0_BIAS;
      3'd1:    a_mag = a_mant + asfe_pkg::ALAW_SEG_BIAS;
      default: a_mag = (a_mant + asfe_pkg::ALAW_SEG_BIAS) << (a_seg - 3'd1);
    endcase
    // Sign bit set means a positive sample in A-law.
    a_lin = a_v[7] ? a_mag : (16'h0000 - a_mag);

    u_v   = ~req.code;
    u_mag = ({9'h000, u_v[3:0], 3'b000} + asfe_pkg::MULAW_BIAS) << u_v[6:4];
    u_lin = u_v[7] ? (asfe_pkg::MULAW_BIAS - u_mag) : (u_mag - asfe_pkg::MULAW_BIAS);

    lin = req.is_mulaw ? u_lin : a_lin;
  end

endmodule

// ----- hdl/audio_sample_format_expander_unit.sv -----
// An accepted word passes the stage 1, 2 and 3 registers on its way to the output.
// Throughput: one word per cycle, three register stages, while out_ready is high.
// A stalled output holds its word while empty stages upstream keep accepting.
// Reset (rst_n low, synchronous) empties all stages and sets the format to 16-bit PCM.
// ----------------------------------------------------------------------------
// audio_sample_format_expander_unit: raw sample word to signed Q1.31
// Converts PCM8/16/24/32, float32, float64, A-law and mu-law samples.
// ----------------------------------------------------------------------------
module audio_sample_format_expander_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_sample_format,
  // Input word channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_raw_sample,
  // Result word channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sample_out,
  output logic               out_clipped
);

  // Stage 1 holds the decoded word. Integer and companded formats are already
  // finished here; floats are reduced to a 53-bit mantissa, a right shift
  // amount and a class that decides saturation.
  typedef struct packed {
    logic        is_flt;
    logic        neg;
    logic        nan;
    logic        big;
    logic        small_val;
    logic [52:0] mant;
    logic [5:0]  sh;
    logic [31:0] word;
  } s1_t;

  // Stage 2 holds the truncated float magnitude next to the carried flags.
  typedef struct packed {
    logic        is_flt;
    logic        neg;
    logic        nan;
    logic        big;
    logic        small_val;
    logic [31:0] mag;
    logic [31:0] word;
  } s2_t;

  asfe_pkg::sample_fmt_t fmt_r;

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  s1_t         s1_nxt, s1_r;
  s2_t         s2_nxt, s2_r;
  logic [31:0] smp_nxt, smp_r;
  logic        clip_nxt, clip_r;

  asfe_pkg::g711_req_t g711_req;
  logic [15:0]         g711_lin;

  logic [7:0]  e32;
  logic [10:0] e64;
  logic [52:0] shifted;

  // The configuration register takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= asfe_pkg::FMT_RESET;
    end else if (cfg_valid) begin
      fmt_r <= asfe_pkg::sample_fmt_t'(cfg_sample_format);
    end
  end

  // A stage can take a new word when it is empty or its word moves on.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------------------------------------------------------- stage 1
  assign g711_req.code     = in_raw_sample[7:0];
  assign g711_req.is_mulaw = (fmt_r == asfe_pkg::FMT_MULAW);

  asfe_g711_exp u_g711 (
    .req (g711_req),
    .lin (g711_lin)
  );

  assign e32 = in_raw_sample[30:23];
  assign e64 = in_raw_sample[62:52];

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.mant      = '0;
    s1_nxt.sh        = '0;
    s1_nxt.word      = '0;
    unique case (fmt_r)
      asfe_pkg::FMT_PCM8: begin
        // Removing the bias of 128 flips the top bit.
        s1_nxt.word = {~in_raw_sample[7], in_raw_sample[6:0], 24'h000000};
      end
      asfe_pkg::FMT_PCM16: begin
        s1_nxt.word = {in_raw_sample[15:0], 16'h0000};
      end
      asfe_pkg::FMT_PCM24: begin
        s1_nxt.word = {in_raw_sample[23:0], 8'h00};
      end
      asfe_pkg::FMT_PCM32: begin
        s1_nxt.word = in_raw_sample[31:0];
      end
      asfe_pkg::FMT_FLOAT32: begin
        // The value's top bit sits at Q1.31 position e - 96. The mantissa is
        // placed at the float64 width so both formats share one shifter.
        s1_nxt.is_flt    = 1'b1;
        s1_nxt.neg       = in_raw_sample[31];
        s1_nxt.nan       = (e32 == 8'hFF) && (in_raw_sample[22:0] != 23'h0);
        s1_nxt.big       = (e32 == 8'hFF && in_raw_sample[22:0] == 23'h0) ||
                           (e32 != 8'hFF && e32[7]);
        s1_nxt.small_val = (e32 < 8'd96);
        s1_nxt.mant      = {1'b1, in_raw_sample[22:0], 29'h0};
        s1_nxt.sh        = 6'(8'd148 - e32);
      end
      asfe_pkg::FMT_FLOAT64: begin
        // Here the top bit sits at Q1.31 position e - 992.
        s1_nxt.is_flt    = 1'b1;
        s1_nxt.neg       = in_raw_sample[63];
        s1_nxt.nan       = (e64 == 11'h7FF) && (in_raw_sample[51:0] != 52'h0);
        s1_nxt.big       = (e64 == 11'h7FF && in_raw_sample[51:0] == 52'h0) ||
                           (e64 != 11'h7FF && e64[10]);
        s1_nxt.small_val = (e64 < 11'd992);
        s1_nxt.mant      = {1'b1, in_raw_sample[51:0]};
        s1_nxt.sh        = 6'(11'd1044 - e64);
      end
      asfe_pkg::FMT_ALAW,
      asfe_pkg::FMT_MULAW: begin
        s1_nxt.word = {g711_lin, 16'h0000};
      end
    endcase
  end

  // ---------------------------------------------------------------- stage 2
  // For a word that reaches the shifter the shift is 21 to 52, so the
  // truncated magnitude fits in 32 bits.
  assign shifted = s1_r.mant >> s1_r.sh;

  always_comb begin
    s2_nxt.is_flt    = s1_r.is_flt;
    s2_nxt.neg       = s1_r.neg;
    s2_nxt.nan       = s1_r.nan;
    s2_nxt.big       = s1_r.big;
    s2_nxt.small_val = s1_r.small_val;
    s2_nxt.mag       = shifted[31:0];
    s2_nxt.word      = s1_r.word;
  end

  // ---------------------------------------------------------------- stage 3
  // Saturation: a positive magnitude of 2^31 or more clips to the largest
  // value, a negative magnitude above 2^31 clips to the smallest. Exactly
  // minus one passes without a clip.
  always_comb begin
    smp_nxt  = s2_r.word;
    clip_nxt = 1'b0;
    if (s2_r.is_flt) begin
      priority if (s2_r.nan) begin
        smp_nxt  = 32'h0000_0000;
        clip_nxt = 1'b1;
      end else if (s2_r.big) begin
        smp_nxt  = s2_r.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        clip_nxt = 1'b1;
      end else if (s2_r.small_val) begin
        smp_nxt  = 32'h0000_0000;
      end else if (!s2_r.neg) begin
        clip_nxt = s2_r.mag[31];
        smp_nxt  = s2_r.mag[31] ? 32'h7FFF_FFFF : s2_r.mag;
      end else begin
        clip_nxt = s2_r.mag[31] && (s2_r.mag[30:0] != 31'h0);
        smp_nxt  = clip_nxt ? 32'h8000_0000 : (32'h0000_0000 - s2_r.mag);
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      smp_r  <= smp_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid      = v3_r;
  assign out_sample_out = smp_r;
  assign out_clipped    = clip_r;

endmodule

// ----- hdl/asfe_port_checker.sv -----
// ----------------------------------------------------------------------------
// asfe_port_checker: port-level checks for the sample format expander
// Watches the top-level handshakes and result words over time.
// ----------------------------------------------------------------------------
module asfe_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample_out,
  input logic        out_clipped
);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A clipped word carries zero or one of the two saturation values.
  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_sample_out == 32'h0000_0000 || out_sample_out == 32'h7FFF_FFFF ||
       out_sample_out == 32'h8000_0000))
    else $error("clipped word with an unsaturated value");

  // With the output empty the pipeline has room for a new word.
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while the output is empty");

  // A word accepted into a draining pipeline shows up on the output once it has moved through every stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result word missing after pipeline latency");

endmodule

bind audio_sample_format_expander_unit asfe_port_checker u_asfe_port_checker (.*);
